>>> hw/rtl/awd_pkg.sv
// Package for the activation unit: widths, mode codes and the sigmoid and
// tanh interpolation tables, which are built at elaboration.
// It depends on nothing else.
package awd_pkg;

   localparam int DATA_WIDTH    = 16;
   localparam int FRAC_BITS     = 12;
   localparam int TABLE_ENTRIES = 256;

   localparam int IDX_BITS   = $clog2(TABLE_ENTRIES);
   localparam int REM_BITS   = FRAC_BITS + 3 - IDX_BITS;
   localparam int SLOPE_BITS = FRAC_BITS + 1;
   localparam int MODE_BITS  = 3;

   localparam logic [SLOPE_BITS-1:0] ONE_Q = SLOPE_BITS'(1 << FRAC_BITS);
   localparam logic [DATA_WIDTH:0] SPAN_Q = (DATA_WIDTH + 1)'(8 << FRAC_BITS);

   localparam logic [MODE_BITS-1:0] MODE_SIGMOID = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_RELU    = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_LINEAR  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_TANH    = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_LIMIT   = 3'd4;

   typedef logic [TABLE_ENTRIES:0][SLOPE_BITS-1:0] rom_type;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   // Unsigned long division, used only while the tables are built.
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Knot k lies at 8*k/TABLE_ENTRIES. The exponential is a truncated series
   // in Q30, and its reciprocal is squared three times; the result is rounded half up.
   function automatic rom_type build_rom(input logic tanh_sel);
      rom_type rom;
      logic [63:0] u;
      logic [63:0] term;
      logic [63:0] e;
      logic [63:0] p;
      logic [63:0] q;
      logic [63:0] v;
      rom = '0;
      for (int k = 0; k <= TABLE_ENTRIES; k++) begin
         u = div_u64(64'(k) << 30, 64'(TABLE_ENTRIES));
         term = Q30_ONE;
         e = Q30_ONE;
         for (int n = 1; n < 40; n++) begin
            if (term != 64'd0) begin
               term = div_u64((term * u) >> 30, 64'(n));
               e = e + term;
            end
         end
         p = div_u64(Q30_ONE << 30, e);
         p = (p * p) >> 30;
         p = (p * p) >> 30;
         p = (p * p) >> 30;
         q = (p * p) >> 30;
         if (tanh_sel) begin
            v = div_u64((Q30_ONE - q) << 30, Q30_ONE + q);
         end else begin
            v = div_u64(Q30_ONE << 30, Q30_ONE + p);
         end
         v = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
         rom[k] = v[SLOPE_BITS-1:0];
      end
      return rom;
   endfunction

   localparam rom_type SIG_ROM = build_rom(1'b0);
   localparam rom_type TNH_ROM = build_rom(1'b1);

endpackage

>>> hw/rtl/activation_with_derivative.sv
// Top level of the activation unit: a six-stage pipeline that gives the
// activated value and its slope for each input transaction.
// It depends on awd_pkg for widths, mode codes and the two tables.
//
// Usage: req_pre_activation is a signed Q4.12 value, taken at an edge where
// req_valid is high and req_stall is low. Each input transaction gives one
// result transaction on rsp_activated (signed Q4.12) and rsp_slope (unsigned,
// 4096 is one), taken where rsp_valid is high and rsp_stall is low.
// The mode is written through csr_valid/csr_ready with csr_activation_mode.
// Write it only while the pipeline is empty; the block does not enforce this.
// csr_ready is always high. rsp_valid rises once a transaction has passed
// the six register stages (absolute value, table read, interpolation
// multiply, function select, slope multiply, output). One transaction can
// enter every cycle while req_stall is low.
// Reset clears all valid bits and sets the mode to sigmoid. While a result
// waits under rsp_stall the whole pipeline holds and req_stall is high, so
// nothing is lost or repeated.
module activation_with_derivative (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [awd_pkg::DATA_WIDTH-1:0]  req_pre_activation,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [awd_pkg::DATA_WIDTH-1:0]  rsp_activated,
   output logic        [awd_pkg::SLOPE_BITS-1:0]  rsp_slope,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [awd_pkg::MODE_BITS-1:0]   csr_activation_mode
);

   localparam int DW = awd_pkg::DATA_WIDTH;
   localparam int SW = awd_pkg::SLOPE_BITS;
   localparam int RW = awd_pkg::REM_BITS;
   localparam int IW = awd_pkg::IDX_BITS;
   localparam int MW = awd_pkg::MODE_BITS;
   localparam int FB = awd_pkg::FRAC_BITS;
   localparam logic signed [DW-1:0] ONE_DATA = DW'(1 << FB);

   logic hold;
   logic [MW-1:0] mode_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [MW-1:0] mode1_ff, mode2_ff, mode3_ff, mode4_ff, mode5_ff;
   logic neg1_ff, neg2_ff, neg3_ff;
   logic pos1_ff, pos2_ff, pos3_ff;
   logic signed [DW-1:0] x1_ff, x2_ff, x3_ff;
   logic [DW-1:0] a1_ff;
   logic [SW-1:0] lo2_ff, hi2_ff, lo3_ff;
   logic [RW-1:0] rem2_ff;
   logic down3_ff;
   logic [SW+RW-1:0] prod3_ff;
   logic signed [DW-1:0] y4_ff, y5_ff;
   logic [2*SW-1:0] prod5_ff;
   logic ypos5_ff;
   logic signed [DW-1:0] act6_ff;
   logic [SW-1:0] slope6_ff;

   logic [DW-1:0] a1_in;
   logic sat2;
   logic [IW-1:0] idx2;
   logic [IW:0] idx2_next;
   awd_pkg::rom_type rom2;
   logic [SW-1:0] lo2_in, hi2_in;
   logic [RW-1:0] rem2_in;
   logic [SW-1:0] diff3;
   logic [SW-1:0] step4, lk4;
   logic signed [DW-1:0] lk4_ext, y4_in;
   logic signed [DW-1:0] ay5;
   logic [SW-1:0] opa5, opb5;
   logic [SW-1:0] sq6;
   logic [SW-1:0] slope6_in;

   assign hold      = v6_ff && rsp_stall;
   assign req_stall = hold;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= awd_pkg::MODE_SIGMOID;
      end else if (csr_valid) begin
         mode_ff <= csr_activation_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (!hold) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // Stage 1: magnitude and sign of the input.
   assign a1_in = req_pre_activation[DW-1] ? DW'(-req_pre_activation)
                                           : DW'(req_pre_activation);

   always_ff @(posedge clock) begin
      if (!hold) begin
         mode1_ff <= mode_ff;
         x1_ff    <= req_pre_activation;
         a1_ff    <= a1_in;
         neg1_ff  <= req_pre_activation[DW-1];
         pos1_ff  <= !req_pre_activation[DW-1] && (req_pre_activation != '0);
      end
   end

   // Stage 2: table read of the two knots around the magnitude.
   assign sat2      = {1'b0, a1_ff} >= awd_pkg::SPAN_Q;
   assign idx2      = a1_ff[RW +: IW];
   assign idx2_next = {1'b0, idx2} + (IW + 1)'(1);
   assign rom2      = (mode1_ff == awd_pkg::MODE_TANH) ? awd_pkg::TNH_ROM
                                                       : awd_pkg::SIG_ROM;

   always_comb begin
      if (sat2) begin
         lo2_in  = rom2[awd_pkg::TABLE_ENTRIES];
         hi2_in  = rom2[awd_pkg::TABLE_ENTRIES];
         rem2_in = '0;
      end else begin
         lo2_in  = rom2[{1'b0, idx2}];
         hi2_in  = rom2[idx2_next];
         rem2_in = a1_ff[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         mode2_ff <= mode1_ff;
         x2_ff    <= x1_ff;
         neg2_ff  <= neg1_ff;
         pos2_ff  <= pos1_ff;
         lo2_ff   <= lo2_in;
         hi2_ff   <= hi2_in;
         rem2_ff  <= rem2_in;
      end
   end

   // Stage 3: interpolation product.
   assign diff3 = (hi2_ff < lo2_ff) ? (lo2_ff - hi2_ff) : (hi2_ff - lo2_ff);

   always_ff @(posedge clock) begin
      if (!hold) begin
         mode3_ff <= mode2_ff;
         x3_ff    <= x2_ff;
         neg3_ff  <= neg2_ff;
         pos3_ff  <= pos2_ff;
         lo3_ff   <= lo2_ff;
         down3_ff <= hi2_ff < lo2_ff;
         prod3_ff <= {{RW{1'b0}}, diff3} * {{SW{1'b0}}, rem2_ff};
      end
   end

   // Stage 4: finish the lookup and pick the activation.
   assign step4   = prod3_ff[RW +: SW];
   assign lk4     = down3_ff ? (lo3_ff - step4) : (lo3_ff + step4);
   assign lk4_ext = DW'(lk4);

   always_comb begin
      case (mode3_ff)
         awd_pkg::MODE_SIGMOID: begin
            y4_in = neg3_ff ? (ONE_DATA - lk4_ext) : lk4_ext;
         end
         awd_pkg::MODE_RELU: begin
            y4_in = pos3_ff ? x3_ff : '0;
         end
         awd_pkg::MODE_LINEAR: begin
            y4_in = x3_ff;
         end
         awd_pkg::MODE_TANH: begin
            y4_in = neg3_ff ? -lk4_ext : lk4_ext;
         end
         default: begin
            y4_in = pos3_ff ? ONE_DATA : '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         mode4_ff <= mode3_ff;
         y4_ff    <= y4_in;
      end
   end

   // Stage 5: slope product, y*(1-y) for sigmoid or y*y for tanh.
   assign ay5 = y4_ff[DW-1] ? -y4_ff : y4_ff;

   always_comb begin
      if (mode4_ff == awd_pkg::MODE_TANH) begin
         opa5 = ay5[SW-1:0];
         opb5 = ay5[SW-1:0];
      end else begin
         opa5 = y4_ff[SW-1:0];
         opb5 = awd_pkg::ONE_Q - y4_ff[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         mode5_ff <= mode4_ff;
         y5_ff    <= y4_ff;
         ypos5_ff <= !y4_ff[DW-1] && (y4_ff != '0);
         prod5_ff <= {{SW{1'b0}}, opa5} * {{SW{1'b0}}, opb5};
      end
   end

   // Stage 6: slope and output register.
   assign sq6 = prod5_ff[FB +: SW];

   always_comb begin
      case (mode5_ff)
         awd_pkg::MODE_SIGMOID: begin
            slope6_in = sq6;
         end
         awd_pkg::MODE_RELU: begin
            slope6_in = ypos5_ff ? awd_pkg::ONE_Q : '0;
         end
         awd_pkg::MODE_TANH: begin
            slope6_in = awd_pkg::ONE_Q - sq6;
         end
         default: begin
            slope6_in = awd_pkg::ONE_Q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         act6_ff   <= y5_ff;
         slope6_ff <= slope6_in;
      end
   end

   assign rsp_valid     = v6_ff;
   assign rsp_activated = act6_ff;
   assign rsp_slope     = slope6_ff;

   // The slope never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_slope <= awd_pkg::ONE_Q))
      else $error("slope above one");

   // In sigmoid mode the activated value stays between zero and one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && mode_ff == awd_pkg::MODE_SIGMOID) |->
      (!rsp_activated[DW-1] && rsp_activated <= ONE_DATA))
      else $error("sigmoid output out of range");

   // A transaction accepted while the pipeline moves reaches the next stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted transaction lost at stage one");

   // A transaction in stage five advances unless the output is stalled.
   assert property (@(posedge clock) disable iff (reset)
      (v5_ff && !hold) |=> v6_ff)
      else $error("transaction lost before output");

endmodule
